FILE: rtl/double_ended_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms, clocked on i_clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes plus the small structs shared between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DATA_W = 32;

    // Operation codes carried on i_mode
    localparam logic [2:0] MODE_LIST       = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [2:0] MODE_SWAP       = 3'd3;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd4;
    localparam logic [2:0] MODE_POP_BACK   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Store port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Occupancy flags from the controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dq_stat;

endpackage

`default_nettype wire

FILE: rtl/dq_store.sv
// ----------------------------------------------------------------------------
// Element store
// Ring of DEPTH words, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire                       i_clk,
    input  dq_pkg::t_mem_ctl          i_ctl,
    input  wire  [IW-1:0]             i_wr_addr,
    input  wire  [dq_pkg::DATA_W-1:0] i_wr_data,
    input  wire  [IW-1:0]             i_rd_addr,
    output logic [dq_pkg::DATA_W-1:0] o_rd_data
);

    logic [dq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [dq_pkg::DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Queue sequencer
// Holds front and count, drives the store and the registered result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int CW    = 7
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input channel
    input  wire                        i_valid,
    input  wire  [2:0]                 i_mode,
    input  wire  signed [31:0]         i_value,
    output logic                       o_stall,
    // output channel
    output logic                       o_valid,
    output logic signed [31:0]         o_element,
    output logic [1:0]                 o_status,
    output logic                       o_last,
    input  wire                        i_stall,
    // store port
    output dq_pkg::t_mem_ctl           o_mem_ctl,
    output logic [IW-1:0]              o_wr_addr,
    output logic [dq_pkg::DATA_W-1:0]  o_wr_data,
    output logic [IW-1:0]              o_rd_addr,
    input  wire  [dq_pkg::DATA_W-1:0]  i_rd_data,
    // occupancy
    output dq_pkg::t_dq_stat           o_stat
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RESP    = 3'd1;
    localparam logic [2:0] S_LIST    = 3'd2;
    localparam logic [2:0] S_SWAP_B  = 3'd3;
    localparam logic [2:0] S_SWAP_WA = 3'd4;
    localparam logic [2:0] S_SWAP_WB = 3'd5;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S  = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [2:0]                r_state, n_state;
    logic [IW-1:0]             r_front, n_front;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_addr, n_addr;
    logic [IW-1:0]             r_addr_b, n_addr_b;
    logic [CW-1:0]             r_left, n_left;
    logic [1:0]                r_status, n_status;
    logic [dq_pkg::DATA_W-1:0] r_tmp;

    logic                      r_out_valid;
    logic signed [31:0]        r_out_element;
    logic [1:0]                r_out_status;
    logic                      r_out_last;

    logic                      out_free;
    logic                      out_load;
    logic signed [31:0]        out_element;
    logic [1:0]                out_status;
    logic                      out_last;

    logic                      full;
    logic                      empty;
    logic [CW-1:0]             ring_off;
    logic [CW:0]               ring_sum;
    logic [IW-1:0]             ring_idx;
    logic [IW-1:0]             front_dec;
    logic [IW-1:0]             front_inc;
    logic [IW-1:0]             addr_inc;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + IW'(1);
    endfunction

    assign full  = (r_count == CNT_MAX);
    assign empty = (r_count == '0);

    // ring position of the back slot (push back) or the back element (swap)
    assign ring_off = (i_mode == dq_pkg::MODE_PUSH_BACK) ? r_count : r_count - CNT_ONE;
    assign ring_sum = (CW+1)'(r_front) + (CW+1)'(ring_off);
    assign ring_idx = (ring_sum >= DEPTH_S) ? IW'(ring_sum - DEPTH_S) : IW'(ring_sum);

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IW'(1);
    assign front_inc = wrap_inc(r_front);
    assign addr_inc  = wrap_inc(r_addr);

    assign out_free = !r_out_valid || !i_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_addr      = r_addr;
        n_addr_b    = r_addr_b;
        n_left      = r_left;
        n_status    = r_status;
        o_mem_ctl   = '0;
        o_rd_addr   = r_addr;
        o_wr_addr   = r_addr;
        o_wr_data   = i_rd_data;
        out_load    = 1'b0;
        out_element = '0;
        out_status  = dq_pkg::ST_OK;
        out_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        dq_pkg::MODE_LIST: begin
                            if (empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr       = r_front;
                                n_addr          = r_front;
                                n_left          = r_count;
                                n_state         = S_LIST;
                            end
                        end
                        dq_pkg::MODE_PUSH_FRONT: begin
                            n_state = S_RESP;
                            if (full) begin
                                n_status = dq_pkg::ST_FULL;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_wr_addr       = front_dec;
                                o_wr_data       = $unsigned(i_value);
                                n_front         = front_dec;
                                n_count         = r_count + CNT_ONE;
                                n_status        = dq_pkg::ST_OK;
                            end
                        end
                        dq_pkg::MODE_PUSH_BACK: begin
                            n_state = S_RESP;
                            if (full) begin
                                n_status = dq_pkg::ST_FULL;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_wr_addr       = ring_idx;
                                o_wr_data       = $unsigned(i_value);
                                n_count         = r_count + CNT_ONE;
                                n_status        = dq_pkg::ST_OK;
                            end
                        end
                        dq_pkg::MODE_SWAP: begin
                            if (empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (r_count == CNT_ONE) begin
                                n_status = dq_pkg::ST_OK;
                                n_state  = S_RESP;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr       = r_front;
                                n_addr          = r_front;
                                n_addr_b        = ring_idx;
                                n_state         = S_SWAP_B;
                            end
                        end
                        dq_pkg::MODE_POP_FRONT: begin
                            n_state = S_RESP;
                            if (empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_front  = front_inc;
                                n_count  = r_count - CNT_ONE;
                                n_status = dq_pkg::ST_OK;
                            end
                        end
                        dq_pkg::MODE_POP_BACK: begin
                            n_state = S_RESP;
                            if (empty) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_count  = r_count - CNT_ONE;
                                n_status = dq_pkg::ST_OK;
                            end
                        end
                        default: begin
                            // undefined operation: taken and dropped
                        end
                    endcase
                end
            end
            S_SWAP_B: begin
                // front word lands in r_tmp, fetch the back word
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_addr_b;
                n_state         = S_SWAP_WA;
            end
            S_SWAP_WA: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_addr;
                o_wr_data       = i_rd_data;
                n_state         = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_addr_b;
                o_wr_data       = r_tmp;
                n_status        = dq_pkg::ST_OK;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            S_LIST: begin
                // one element per free output slot; next read overlaps
                if (out_free) begin
                    out_load    = 1'b1;
                    out_element = $signed(i_rd_data);
                    out_last    = (r_left == CNT_ONE);
                    if (r_left == CNT_ONE) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = addr_inc;
                        n_addr          = addr_inc;
                        n_left          = r_left - CNT_ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_addr_b <= n_addr_b;
        r_left   <= n_left;
        r_status <= n_status;
        if (r_state == S_SWAP_B) begin
            r_tmp <= i_rd_data;
        end
        if (out_load) begin
            r_out_element <= out_element;
            r_out_status  <= out_status;
            r_out_last    <= out_last;
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_element    = r_out_element;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_valid / o_stall         | i_mode, i_value
//  output  | out       | o_valid / i_stall         | o_element, o_status, o_last
//
//  Push, pop, refused or empty: one word once the output is free. Swap of two
//  or more elements: front and back read in turn through the single store read
//  port, then both written. List: a fetch, then 1 element per free cycle.
//  Synchronous active-low reset empties the queue; store contents stay stale.
//  A stalled output holds its word; the sequencer waits for the slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
    parameter int DEPTH = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  wire  [2:0]         i_mode,
    input  wire  signed [31:0] i_value,
    output logic               o_stall,
    output logic               o_valid,
    output logic signed [31:0] o_element,
    output logic [1:0]         o_status,
    output logic               o_last,
    input  wire                i_stall
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::t_mem_ctl          mem_ctl;
    logic [IW-1:0]             wr_addr;
    logic [dq_pkg::DATA_W-1:0] wr_data;
    logic [IW-1:0]             rd_addr;
    logic [dq_pkg::DATA_W-1:0] rd_data;
    dq_pkg::t_dq_stat          stat;

    // sequencer and output register
    dq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_mode    (i_mode),
        .i_value   (i_value),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_element (o_element),
        .o_status  (o_status),
        .o_last    (o_last),
        .i_stall   (i_stall),
        .o_mem_ctl (mem_ctl),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_stat    (stat)
    );

    // ring store
    dq_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // checks
    `DQ_ASSERT_SAME(a_occ_excl, 1'b1, !(stat.full && stat.empty), "queue both full and empty")
    `DQ_ASSERT_SAME(a_err_last, o_valid && (o_status != dq_pkg::ST_OK), o_last, "error word not last")
    `DQ_ASSERT_NEXT(a_push_fill, i_valid && !o_stall && !stat.full && ((i_mode == dq_pkg::MODE_PUSH_FRONT) || (i_mode == dq_pkg::MODE_PUSH_BACK)), !stat.empty, "push left queue empty")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives mode/value words into the deque and checks every result word
// against a behavioural deque kept alongside. Directed corner cases come
// first (empty queue, single element, signed extremes, unused modes), then
// a random fill that reaches a full queue, and short mixed and drain phases.
// Both sides idle at random. A watchdog ends a run that makes no progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 5000;

    // Modes with no meaning; the block drops these words
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] value;
        int                 gap;
    } t_cmd_word;

    typedef struct {
        logic signed [31:0] element;
        logic [1:0]         status;
        logic               last;
    } t_result_word;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [2:0]         i_mode  = dq_pkg::MODE_LIST;
    logic signed [31:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_element;
    logic [1:0]         o_status;
    logic               o_last;

    t_cmd_word    pending_cmds[$];
    t_result_word expected_results[$];

    // Behavioural deque state
    logic signed [31:0] deque_store [DEPTH];
    int                 deque_front;
    int                 deque_count;

    int error_count   = 0;
    int gap_wait      = 0;
    int stall_left    = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int gen_count     = 0;
    int queued_total  = 0;

    double_ended_queue_top #(.DEPTH(DEPTH)) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_mode    (i_mode),
        .i_value   (i_value),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_element (o_element),
        .o_status  (o_status),
        .o_last    (o_last),
        .i_stall   (i_stall)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Append one expected result word of an accepted command
    function automatic void add_result(logic signed [31:0] element, logic [1:0] status,
                                       logic last);
        t_result_word w;
        w.element = element;
        w.status  = status;
        w.last    = last;
        expected_results.push_back(w);
    endfunction

    function automatic void deque_apply(logic [2:0] mode, logic signed [31:0] value);
        int a;
        int b;
        logic signed [31:0] t;
        case (mode)
            dq_pkg::MODE_LIST: begin
                if (deque_count == 0) begin
                    add_result('0, dq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < deque_count; i++)
                        add_result(deque_store[(deque_front + i) % DEPTH], dq_pkg::ST_OK,
                                   i == deque_count - 1);
                end
            end
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
                if (deque_count >= DEPTH) begin
                    add_result('0, dq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (mode == dq_pkg::MODE_PUSH_FRONT) begin
                        deque_front = (deque_front + DEPTH - 1) % DEPTH;
                        deque_store[deque_front] = value;
                    end else begin
                        deque_store[(deque_front + deque_count) % DEPTH] = value;
                    end
                    deque_count++;
                    add_result('0, dq_pkg::ST_OK, 1'b1);
                end
            end
            dq_pkg::MODE_SWAP: begin
                if (deque_count == 0) begin
                    add_result('0, dq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    a = deque_front;
                    b = (deque_front + deque_count - 1) % DEPTH;
                    t = deque_store[a];
                    deque_store[a] = deque_store[b];
                    deque_store[b] = t;
                    add_result('0, dq_pkg::ST_OK, 1'b1);
                end
            end
            dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
                if (deque_count == 0) begin
                    add_result('0, dq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    if (mode == dq_pkg::MODE_POP_FRONT)
                        deque_front = (deque_front + 1) % DEPTH;
                    deque_count--;
                    add_result('0, dq_pkg::ST_OK, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // Queue a command; every third run of 16 goes with no gaps
    function automatic void queue_cmd(logic [2:0] mode, logic signed [31:0] value);
        t_cmd_word c;
        c.mode  = mode;
        c.value = value;
        c.gap   = ((queued_total / 16) % 3 == 0) ? 0 : $urandom_range(0, 15);
        pending_cmds.push_back(c);
        queued_total++;
        if ((mode == dq_pkg::MODE_PUSH_FRONT || mode == dq_pkg::MODE_PUSH_BACK) &&
            gen_count < DEPTH)
            gen_count++;
        else if ((mode == dq_pkg::MODE_POP_FRONT || mode == dq_pkg::MODE_POP_BACK) &&
                 gen_count > 0)
            gen_count--;
    endfunction

    function automatic logic [2:0] any_push();
        return $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_FRONT : dq_pkg::MODE_PUSH_BACK;
    endfunction

    function automatic logic [2:0] any_pop();
        return $urandom_range(0, 1) ? dq_pkg::MODE_POP_FRONT : dq_pkg::MODE_POP_BACK;
    endfunction

    // Command driver
    always @(posedge i_clk) begin
        t_cmd_word nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_mode   <= dq_pkg::MODE_LIST;
            i_value  <= '0;
            gap_wait <= 0;
        end else if (i_valid && !o_stall) begin
            deque_apply(i_mode, i_value);
            gap_wait <= 0;
            if (pending_cmds.size() != 0 && pending_cmds[0].gap == 0) begin
                nxt = pending_cmds.pop_front();
                i_mode  <= nxt.mode;
                i_value <= nxt.value;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && pending_cmds.size() != 0) begin
            if (gap_wait < pending_cmds[0].gap) begin
                gap_wait <= gap_wait + 1;
            end else begin
                nxt = pending_cmds.pop_front();
                i_mode   <= nxt.mode;
                i_value  <= nxt.value;
                i_valid  <= 1'b1;
                gap_wait <= 0;
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge i_clk) begin
        t_result_word w;
        int n;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: expected no word, actual element %0d status %0d last %0d",
                             $time, o_element, o_status, o_last);
                    error_count++;
                end else begin
                    w = expected_results.pop_front();
                    if (o_element !== w.element) begin
                        $display("%0t: element expected %0d actual %0d",
                                 $time, w.element, o_element);
                        error_count++;
                    end
                    if (o_status !== w.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, w.status, o_status);
                        error_count++;
                    end
                    if (o_last !== w.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, w.last, o_last);
                        error_count++;
                    end
                end
                results_seen++;
                n = ((results_seen / 24) % 3 == 0) ? 0 : $urandom_range(0, 15);
            end else if (stall_left != 0) begin
                n = stall_left - 1;
            end else begin
                n = 0;
            end
            stall_left <= n;
            i_stall    <= (n != 0);
        end
    end

    // Progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        int counted;

        deque_front = 0;
        deque_count = 0;

        // Directed: empty queue, single element, signed extremes, unused modes
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(dq_pkg::MODE_POP_FRONT, '0);
        queue_cmd(dq_pkg::MODE_POP_BACK, '0);
        queue_cmd(dq_pkg::MODE_SWAP, '0);
        queue_cmd(dq_pkg::MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_cmd(dq_pkg::MODE_SWAP, '0);
        queue_cmd(dq_pkg::MODE_LIST, '1);
        queue_cmd(dq_pkg::MODE_POP_BACK, '0);
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(dq_pkg::MODE_PUSH_BACK, 32'sh8000_0000);
        queue_cmd(dq_pkg::MODE_PUSH_FRONT, -32'sd1);
        queue_cmd(dq_pkg::MODE_PUSH_BACK, '0);
        queue_cmd(dq_pkg::MODE_PUSH_FRONT, 32'sd1);
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(dq_pkg::MODE_SWAP, 32'sh1234_5678);
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(dq_pkg::MODE_POP_FRONT, '1);
        queue_cmd(dq_pkg::MODE_POP_BACK, '0);
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(MODE_UNUSED_6, 32'sh5A5A_5A5A);
        queue_cmd(MODE_UNUSED_7, '1);
        queue_cmd(dq_pkg::MODE_PUSH_BACK, 32'sh5555_5555);
        queue_cmd(dq_pkg::MODE_PUSH_FRONT, 32'shAAAA_AAAA);
        queue_cmd(dq_pkg::MODE_LIST, '0);

        // Fill to the brim with the odd list or swap, then bounce off full
        while (gen_count < DEPTH) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                queue_cmd(dq_pkg::MODE_LIST, $urandom);
            else if (r == 1)
                queue_cmd(dq_pkg::MODE_SWAP, $urandom);
            else
                queue_cmd(any_push(), $urandom);
        end
        queue_cmd(dq_pkg::MODE_PUSH_FRONT, $urandom);
        queue_cmd(dq_pkg::MODE_PUSH_BACK, $urandom);
        queue_cmd(dq_pkg::MODE_SWAP, '0);
        queue_cmd(dq_pkg::MODE_LIST, '0);
        queue_cmd(dq_pkg::MODE_PUSH_BACK, $urandom);

        // Mixed traffic; unused modes are noise and not counted
        counted = 0;
        while (counted < 10) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_cmd(any_push(), $urandom);
            else if (r < 75)
                queue_cmd(any_pop(), $urandom);
            else if (r < 85)
                queue_cmd(dq_pkg::MODE_SWAP, $urandom);
            else if (r < 95)
                queue_cmd(dq_pkg::MODE_LIST, $urandom);
            else
                queue_cmd($urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7, $urandom);
            if (r < 95)
                counted++;
        end

        // Short drain, then a last pop front, pop back, swap and list
        counted = 0;
        while (counted < 10) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                queue_cmd(dq_pkg::MODE_SWAP, $urandom);
            else if (r == 1)
                queue_cmd(dq_pkg::MODE_LIST, $urandom);
            else
                queue_cmd(any_pop(), $urandom);
            counted++;
        end
        queue_cmd(dq_pkg::MODE_POP_FRONT, $urandom);
        queue_cmd(dq_pkg::MODE_POP_BACK, $urandom);
        queue_cmd(dq_pkg::MODE_SWAP, $urandom);
        queue_cmd(dq_pkg::MODE_LIST, $urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let the stimulus run out, then the results
        while (pending_cmds.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 40) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
